// File: hdl/gaussian_background_model_defines.svh
// Assertion macros shared by the background model RTL.
`ifndef GAUSSIAN_BACKGROUND_MODEL_DEFINES_SVH
`define GAUSSIAN_BACKGROUND_MODEL_DEFINES_SVH

// Check that expr holds in every cycle in which cond holds.
`define GBM_ASSERT_IMPL(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Check that expr holds in the cycle in which sig rises.
`define GBM_ASSERT_ROSE(label, sig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) $rose(sig) |-> (expr)) \
		else $error(msg);

`endif

// File: hdl/gbm_pkg.sv
// Package: shared types and constants of the background model.
`timescale 1ns / 1ps
package gbm_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_FACTOR      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_DEVIATION = 3'd4;

	localparam logic [9:0]  RST_FRAME_WIDTH       = 10'd320;
	localparam logic [9:0]  RST_FRAME_HEIGHT      = 10'd240;
	localparam logic [15:0] RST_LEARNING_RATE     = 16'd655;
	localparam logic [3:0]  RST_MATCH_FACTOR      = 4'd3;
	localparam logic [7:0]  RST_INITIAL_DEVIATION = 8'd36;

	// 1.0 in 0.16 format, one bit wider than a 0.16 word
	localparam logic [16:0] ALPHA_ONE  = 17'h10000;
	localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;

	localparam int QUEUE_DEPTH = 2;

	localparam int DIV_BITS    = 16;
	localparam int DIV_STAGES  = 8;
	localparam int SQRT_IN_W   = 32;
	localparam int SQRT_STAGES = 8;

	localparam int STORE_W = 48;

	typedef enum logic [1:0] {
		OP_INIT,
		OP_UPDATE,
		OP_PASS
	} op_t;

	typedef struct packed {
		logic [9:0]  frame_width;
		logic [9:0]  frame_height;
		logic [15:0] learning_rate;
		logic [3:0]  match_factor;
		logic [7:0]  initial_deviation;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] pix;
	} fe_item_t;

	typedef struct packed {
		op_t                op;
		logic [7:0]         pix;
		logic [15:0]        mean;
		logic [15:0]        dev;
		logic [15:0]        wt;
		logic               match;
		logic [31:0]        decay_prod;
		logic [15:0]        wnew;
		logic               pfull;
		logic [31:0]        dev2;
		logic [15:0]        quo;
		logic signed [34:0] mprod;
		logic [15:0]        mnew;
		logic [31:0]        d2;
		logic signed [50:0] vprod;
	} back_item_t;

	typedef struct packed {
		logic busy;
		logic hazard;
		logic issue;
	} back_status_t;

endpackage

// File: hdl/gbm_if.sv
// Interfaces: pixel input channel and result output channel.
`timescale 1ns / 1ps
interface gbm_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic       start_of_frame;

	modport source (output valid, output pixel_value, output start_of_frame, input ready);
	modport sink (input valid, input pixel_value, input start_of_frame, output ready);
endinterface

interface gbm_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] background_value;
	logic       row_updated;
	logic       model_matched;

	modport source (output valid, output background_value, output row_updated,
		output model_matched, input ready);
	modport sink (input valid, input background_value, input row_updated,
		input model_matched, output ready);
endinterface

// File: hdl/gbm_div.sv
// Pipelined restoring divider: quotient of (num << 16) / den for num < den.
`timescale 1ns / 1ps
module gbm_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [gbm_pkg::DIV_BITS-1:0] num,
	input  logic [gbm_pkg::DIV_BITS-1:0] den,
	output logic [gbm_pkg::DIV_BITS-1:0] quo
);
	import gbm_pkg::*;

	localparam int STEPS = DIV_BITS / DIV_STAGES;

	logic [DIV_BITS-1:0] rem_q [DIV_STAGES];
	logic [DIV_BITS-1:0] den_q [DIV_STAGES];
	logic [DIV_BITS-1:0] quo_q [DIV_STAGES];
	logic [DIV_BITS-1:0] rem_n [DIV_STAGES];
	logic [DIV_BITS-1:0] den_n [DIV_STAGES];
	logic [DIV_BITS-1:0] quo_n [DIV_STAGES];

	always_comb begin
		logic [DIV_BITS-1:0] r;
		logic [DIV_BITS-1:0] d;
		logic [DIV_BITS-1:0] q;
		logic [DIV_BITS:0]   t;
		for (int s = 0; s < DIV_STAGES; s++) begin
			if (s == 0) begin
				r = num;
				d = den;
				q = '0;
			end else begin
				r = rem_q[s-1];
				d = den_q[s-1];
				q = quo_q[s-1];
			end
			for (int i = 0; i < STEPS; i++) begin
				t = {r, 1'b0};
				if (t >= {1'b0, d}) begin
					t = t - {1'b0, d};
					q = {q[DIV_BITS-2:0], 1'b1};
				end else begin
					q = {q[DIV_BITS-2:0], 1'b0};
				end
				r = t[DIV_BITS-1:0];
			end
			rem_n[s] = r;
			den_n[s] = d;
			quo_n[s] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < DIV_STAGES; s++) begin
				rem_q[s] <= rem_n[s];
				den_q[s] <= den_n[s];
				quo_q[s] <= quo_n[s];
			end
		end
	end

	assign quo = quo_q[DIV_STAGES-1];
endmodule

// File: hdl/gbm_sqrt.sv
// Pipelined digit-by-digit integer square root, two result bits per stage.
`timescale 1ns / 1ps
module gbm_sqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [gbm_pkg::SQRT_IN_W-1:0]   radicand,
	output logic [gbm_pkg::SQRT_IN_W/2-1:0] root
);
	import gbm_pkg::*;

	localparam int RW    = SQRT_IN_W / 2;
	localparam int STEPS = RW / SQRT_STAGES;
	localparam int REMW  = RW + 2;

	logic [REMW-1:0]      rem_q  [SQRT_STAGES];
	logic [RW-1:0]        root_q [SQRT_STAGES];
	logic [SQRT_IN_W-1:0] v_q    [SQRT_STAGES];
	logic [REMW-1:0]      rem_n  [SQRT_STAGES];
	logic [RW-1:0]        root_n [SQRT_STAGES];
	logic [SQRT_IN_W-1:0] v_n    [SQRT_STAGES];

	always_comb begin
		logic [REMW+1:0]      rm;
		logic [REMW+1:0]      t;
		logic [RW-1:0]        rt;
		logic [SQRT_IN_W-1:0] v;
		for (int s = 0; s < SQRT_STAGES; s++) begin
			if (s == 0) begin
				rm = '0;
				rt = '0;
				v  = radicand;
			end else begin
				rm = (REMW+2)'(rem_q[s-1]);
				rt = root_q[s-1];
				v  = v_q[s-1];
			end
			for (int i = 0; i < STEPS; i++) begin
				rm = {rm[REMW-1:0], v[SQRT_IN_W-1:SQRT_IN_W-2]};
				v  = {v[SQRT_IN_W-3:0], 2'b00};
				t  = {2'b00, rt, 2'b01};
				if (rm >= t) begin
					rm = rm - t;
					rt = {rt[RW-2:0], 1'b1};
				end else begin
					rt = {rt[RW-2:0], 1'b0};
				end
			end
			rem_n[s]  = rm[REMW-1:0];
			root_n[s] = rt;
			v_n[s]    = v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < SQRT_STAGES; s++) begin
				rem_q[s]  <= rem_n[s];
				root_q[s] <= root_n[s];
				v_q[s]    <= v_n[s];
			end
		end
	end

	assign root = root_q[SQRT_STAGES-1];
endmodule

// File: hdl/gbm_front.sv
// Front end: position counters, pixel classification and the issue queue.
`timescale 1ns / 1ps
module gbm_front #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int AW = CW + RW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbm_pkg::cfg_t     cfg,
	gbm_pixel_if.sink         pixels,
	output gbm_pkg::fe_item_t q_item,
	output logic [AW-1:0]     q_addr,
	output logic              q_valid,
	input  logic              q_pop
);
	import gbm_pkg::*;

	localparam int WSW = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
	localparam int HSW = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;
	localparam int QPW = $clog2(QUEUE_DEPTH);

	logic [CW-1:0]  col_q, col_cur;
	logic [RW-1:0]  row_q, row_cur, active_q;
	logic           init_q;
	logic [WSW-1:0] w_eff, fw_ext;
	logic [HSW-1:0] h_eff, fh_ext;
	logic           last_col, last_row, last_active;
	logic           push;
	fe_item_t       new_item;

	fe_item_t       slot_q [QUEUE_DEPTH];
	logic [AW-1:0]  slot_addr_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPW:0]   count_q;

	// clamp sizes to 1..MAX
	always_comb begin
		fw_ext = WSW'(cfg.frame_width);
		fh_ext = HSW'(cfg.frame_height);
		if (fw_ext == '0) w_eff = WSW'(1);
		else if (fw_ext > WSW'(MAX_WIDTH)) w_eff = WSW'(MAX_WIDTH);
		else w_eff = fw_ext;
		if (fh_ext == '0) h_eff = HSW'(1);
		else if (fh_ext > HSW'(MAX_HEIGHT)) h_eff = HSW'(MAX_HEIGHT);
		else h_eff = fh_ext;
	end

	assign col_cur     = pixels.start_of_frame ? '0 : col_q;
	assign row_cur     = pixels.start_of_frame ? '0 : row_q;
	assign last_col    = (WSW'(col_cur) + WSW'(1)) >= w_eff;
	assign last_row    = (HSW'(row_cur) + HSW'(1)) >= h_eff;
	assign last_active = (HSW'(active_q) + HSW'(1)) >= h_eff;

	always_comb begin
		new_item.pix = pixels.pixel_value;
		if (!init_q) new_item.op = OP_INIT;
		else if (row_cur == active_q) new_item.op = OP_UPDATE;
		else new_item.op = OP_PASS;
	end

	assign pixels.ready = count_q != (QPW+1)'(QUEUE_DEPTH);
	assign push         = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			active_q <= '0;
			init_q   <= 1'b0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
					if (!init_q) init_q <= 1'b1;
					else active_q <= last_active ? '0 : active_q + RW'(1);
				end else begin
					row_q <= row_cur + RW'(1);
				end
			end else begin
				col_q <= col_cur + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPW'(1);
			if (q_pop) rd_ptr_q <= rd_ptr_q + QPW'(1);
			if (push && !q_pop) count_q <= count_q + (QPW+1)'(1);
			else if (q_pop && !push) count_q <= count_q - (QPW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q]      <= new_item;
			slot_addr_q[wr_ptr_q] <= {row_cur, col_cur};
		end
	end

	assign q_valid = count_q != '0;
	assign q_item  = slot_q[rd_ptr_q];
	assign q_addr  = slot_addr_q[rd_ptr_q];
endmodule

// File: hdl/gbm_back.sv
// Back end: model store, update pipeline, write-back and result stage.
`timescale 1ns / 1ps
module gbm_back #(
	parameter int ADDR_W = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gbm_pkg::cfg_t        cfg,
	input  gbm_pkg::fe_item_t    q_item,
	input  logic [ADDR_W-1:0]    q_addr,
	input  logic                 q_valid,
	output logic                 q_pop,
	gbm_result_if.source         results,
	output gbm_pkg::back_status_t status
);
	import gbm_pkg::*;

	localparam int DS  = 1 + DIV_STAGES;
	localparam int VS  = DS + 4;
	localparam int WS  = VS + SQRT_STAGES;
	localparam int NST = WS + 1;

	logic [STORE_W-1:0] store_q [0:(1 << ADDR_W)-1];
	logic [STORE_W-1:0] rdata_q;

	logic [NST-1:0]    valid_q;
	back_item_t        item_q [NST];
	back_item_t        nxt [NST-1];
	logic [ADDR_W-1:0] addr_q [NST];
	back_item_t        issue_item;

	logic        en, issue, hazard;
	logic [15:0] div_num, div_den, div_quo;
	logic [31:0] sqrt_in;
	logic [15:0] sqrt_root;

	logic [7:0]         diff;
	logic [19:0]        band;
	logic [16:0]        one_minus_a;
	logic [15:0]        decayed, wn;
	logic [16:0]        wn_sum;
	logic signed [17:0] pval_s, mdiff_s, dd;
	logic signed [35:0] msum, d2full;
	logic signed [33:0] vdiff;
	logic signed [51:0] vsum;

	back_item_t         sw;
	logic               mt;
	logic               wr;
	logic [STORE_W-1:0] wdata;
	logic [7:0]         bg;

	// stall the whole pipeline while the result stage holds an untaken word
	assign en = !valid_q[WS] || results.ready;

	// hold the queue head while a write to its location is still in flight
	always_comb begin
		hazard = 1'b0;
		for (int k = 0; k < NST; k++) begin
			if (valid_q[k] && item_q[k].op != OP_PASS && addr_q[k] == q_addr) hazard = 1'b1;
		end
	end

	assign issue = en && q_valid && !hazard;
	assign q_pop = issue;

	always_comb begin
		issue_item     = '0;
		issue_item.op  = q_item.op;
		issue_item.pix = q_item.pix;
	end

	always_comb begin
		for (int k = 0; k < NST-1; k++) nxt[k] = item_q[k];

		// read data, match band and weight decay
		nxt[0].mean  = rdata_q[47:32];
		nxt[0].dev   = rdata_q[31:16];
		nxt[0].wt    = rdata_q[15:0];
		diff         = (item_q[0].pix > rdata_q[47:40]) ? item_q[0].pix - rdata_q[47:40]
		                                                : rdata_q[47:40] - item_q[0].pix;
		band         = 20'(cfg.match_factor) * 20'(rdata_q[31:16]);
		nxt[0].match = {4'b0000, diff, 8'h00} <= band;
		one_minus_a  = ALPHA_ONE - 17'(cfg.learning_rate);
		nxt[0].decay_prod = 32'(rdata_q[15:0]) * 32'(one_minus_a);

		// new weight, ratio setup and old variance
		decayed = 16'((33'(item_q[1].decay_prod) + 33'd32768) >> 16);
		wn_sum  = 17'(decayed) + 17'(cfg.learning_rate);
		wn      = wn_sum[16] ? WEIGHT_MAX : wn_sum[15:0];
		nxt[1].wnew  = item_q[1].match ? wn : decayed;
		nxt[1].pfull = cfg.learning_rate >= wn;
		nxt[1].dev2  = 32'(item_q[1].dev) * 32'(item_q[1].dev);
		div_num = cfg.learning_rate;
		div_den = wn;

		// mean blend product
		nxt[DS].quo  = div_quo;
		pval_s       = item_q[DS].pfull ? $signed({1'b0, ALPHA_ONE}) : $signed({2'b00, div_quo});
		mdiff_s      = $signed({2'b00, item_q[DS].pix, 8'h00}) - $signed({2'b00, item_q[DS].mean});
		nxt[DS].mprod = 35'(pval_s) * 35'(mdiff_s);

		// new mean
		msum = $signed({4'b0000, item_q[DS+1].mean, 16'h0000}) + 36'(item_q[DS+1].mprod)
		       + 36'sd32768;
		nxt[DS+1].mnew = msum[31:16];

		// squared distance to the new mean
		dd     = $signed({2'b00, item_q[DS+2].pix, 8'h00}) - $signed({2'b00, item_q[DS+2].mnew});
		d2full = 36'(dd) * 36'(dd);
		nxt[DS+2].d2 = d2full[31:0];

		// variance blend product
		vdiff = $signed({2'b00, item_q[DS+3].d2}) - $signed({2'b00, item_q[DS+3].dev2});
		nxt[DS+3].vprod = 51'($signed({1'b0, item_q[DS+3].quo})) * 51'(vdiff);

		// new variance into the root unit
		vsum = $signed({4'h0, item_q[VS].dev2, 16'h0000}) + 52'(item_q[VS].vprod) + 52'sd32768;
		sqrt_in = item_q[VS].pfull ? item_q[VS].d2 : vsum[47:16];
	end

	gbm_div u_div (
		.clk (clk),
		.en  (en),
		.num (div_num),
		.den (div_den),
		.quo (div_quo)
	);

	gbm_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sqrt_in),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NST-2:0], issue};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q[0] <= issue_item;
			addr_q[0] <= q_addr;
			rdata_q   <= store_q[q_addr];
			for (int k = 1; k < NST; k++) begin
				item_q[k] <= nxt[k-1];
				addr_q[k] <= addr_q[k-1];
			end
		end
	end

	// write-back and result
	always_comb begin
		sw = item_q[WS];
		mt = sw.op == OP_UPDATE && sw.match;
		case (sw.op)
			OP_INIT: begin
				wdata = {sw.pix, 8'h00, cfg.initial_deviation, 8'h00, WEIGHT_MAX};
				bg    = sw.pix;
			end
			OP_UPDATE: begin
				wdata = {mt ? sw.mnew : sw.mean, mt ? sqrt_root : sw.dev, sw.wnew};
				bg    = mt ? sw.mnew[15:8] : sw.mean[15:8];
			end
			default: begin
				wdata = {sw.mean, sw.dev, sw.wt};
				bg    = sw.mean[15:8];
			end
		endcase
	end

	assign wr = en && valid_q[WS] && sw.op != OP_PASS;

	always_ff @(posedge clk) begin
		if (wr) store_q[addr_q[WS]] <= wdata;
	end

	assign results.valid            = valid_q[WS];
	assign results.background_value = bg;
	assign results.row_updated      = sw.op == OP_UPDATE;
	assign results.model_matched    = mt;

	assign status.busy   = |valid_q;
	assign status.hazard = hazard;
	assign status.issue  = issue;
endmodule

// File: hdl/gaussian_background_model.sv
// Top level: single-Gaussian running-average background model.
`timescale 1ns / 1ps
`include "gaussian_background_model_defines.svh"
// Usage
//   pixels: one gray pixel word per handshake, raster order; start_of_frame
//     marks the first pixel of a frame and resets the position counters.
//   results: one word per pixel, in order: background_value is the integer
//     part of the pixel's mean after its update, row_updated flags the frame's
//     active row, model_matched flags an update that fell in the match band.
//   cfg_write/cfg_index/cfg_data: write a register (0 width, 1 height,
//     2 learning rate, 3 match factor, 4 initial deviation) while idle.
// Timing
//   Sustained rate is one pixel per clock while results are taken and no
//   pixel waits on a pending write. After its acceptance a pixel passes
//   through the queue, the store read, the weight stages, the 8-stage divider
//   for the learning ratio, four blend stages, the 8-stage square root and
//   the result stage. A pixel whose store location still has a write in the
//   pipeline waits in the queue, which slows frames of few pixels.
// Reset
//   Clears counters, queue and pipeline and loads the register defaults; the
//   first frame after reset seeds the store, no clearing pass is run.
// Stalls: a stalled result freezes the whole back pipeline; the two-word
//   queue keeps taking pixels until it fills, then pixels.ready drops.
module gaussian_background_model #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gbm_pixel_if.sink                       pixels,
	gbm_result_if.source                    results,
	input  logic                            cfg_write,
	input  logic [gbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gbm_pkg::*;

	localparam int ADDR_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

	cfg_t              cfg_q;
	fe_item_t          q_item;
	logic [ADDR_W-1:0] q_addr;
	logic              q_valid, q_pop;
	back_status_t      back_status;

	// register file; the user writes it only while the block is idle, unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width       <= RST_FRAME_WIDTH;
			cfg_q.frame_height      <= RST_FRAME_HEIGHT;
			cfg_q.learning_rate     <= RST_LEARNING_RATE;
			cfg_q.match_factor      <= RST_MATCH_FACTOR;
			cfg_q.initial_deviation <= RST_INITIAL_DEVIATION;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:       cfg_q.frame_width       <= cfg_data[9:0];
				REG_FRAME_HEIGHT:      cfg_q.frame_height      <= cfg_data[9:0];
				REG_LEARNING_RATE:     cfg_q.learning_rate     <= cfg_data[15:0];
				REG_MATCH_FACTOR:      cfg_q.match_factor      <= cfg_data[3:0];
				REG_INITIAL_DEVIATION: cfg_q.initial_deviation <= cfg_data[7:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// classify and queue each accepted pixel word
	gbm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.pixels  (pixels),
		.q_item  (q_item),
		.q_addr  (q_addr),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// read, update and write back the model, then present the result word
	gbm_back #(
		.ADDR_W (ADDR_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_item  (q_item),
		.q_addr  (q_addr),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.results (results),
		.status  (back_status)
	);

	`GBM_ASSERT_IMPL(a_match_needs_update, results.valid && results.model_matched, results.row_updated, "model_matched without row_updated")
	`GBM_ASSERT_IMPL(a_no_issue_on_hazard, back_status.hazard, !back_status.issue, "queue head issued over a pending write")
	`GBM_ASSERT_ROSE(a_result_from_pipe, results.valid, $past(back_status.busy), "result appeared from an empty pipeline")
endmodule

// File: tb/tb.sv
// Testbench for the gaussian_background_model block: self-checking, with random stimulus.
`timescale 1ns / 1ps
module tb;
	import gbm_pkg::*;

	localparam int MAXW = 512;
	localparam int MAXH = 512;
	localparam int FLUSH_CYCLES = 40;	// well past the pipeline's length
	localparam longint CYCLE_LIMIT = 600000;

	// One result word as the block should produce it.
	typedef struct packed {
		logic [7:0] background_value;
		logic       row_updated;
		logic       model_matched;
	} bg_word_t;

	// Background scoreboard: keeps a private copy of the per-pixel Gaussians,
	// predicts each result word and checks the block's words against it.
	class bg_scoreboard;
		bit [15:0] mean_mem [int];
		bit [15:0] dev_mem [int];
		bit [15:0] wt_mem [int];
		bit        seeded;
		int unsigned act_row, col_pos, row_pos;
		bit [9:0]  fw, fh;
		bit [15:0] alpha;
		bit [3:0]  band;
		bit [7:0]  dev_init;
		bg_word_t  pending_words[$];
		int        errors;

		function new();
			seeded = 0; act_row = 0; col_pos = 0; row_pos = 0;
			fw = RST_FRAME_WIDTH; fh = RST_FRAME_HEIGHT; alpha = RST_LEARNING_RATE;
			band = RST_MATCH_FACTOR; dev_init = RST_INITIAL_DEVIATION;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_FRAME_WIDTH:       fw = val[9:0];
				REG_FRAME_HEIGHT:      fh = val[9:0];
				REG_LEARNING_RATE:     alpha = val;
				REG_MATCH_FACTOR:      band = val[3:0];
				REG_INITIAL_DEVIATION: dev_init = val[7:0];
				default: ;
			endcase
		endfunction

		static function int unsigned clamp_dim(int unsigned v, int unsigned lim);
			if (v < 1) return 1;
			if (v > lim) return lim;
			return v;
		endfunction

		static function longint unsigned root_floor(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 30;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// Integer part of the stored mean at the position the next word lands on.
		function int next_mean(bit sof);
			int unsigned c, r;
			int key;
			c = sof ? 0 : col_pos;
			r = sof ? 0 : row_pos;
			if (c >= MAXW) c = 0;
			if (r >= MAXH) r = 0;
			key = r * MAXW + c;
			return mean_mem.exists(key) ? mean_mem[key] >> 8 : 128;
		endfunction

		// Advance the model by one accepted pixel word and queue its result.
		function void note_pixel(bit [7:0] pix, bit sof);
			int unsigned w, h;
			int key;
			bg_word_t exp_w;
			longint unsigned a, mean, dev, wt, mint, diff, decayed, wn, p, q, mnew, var_n, d2;
			longint d;
			w = clamp_dim(fw, MAXW);
			h = clamp_dim(fh, MAXH);
			if (sof) begin
				col_pos = 0;
				row_pos = 0;
			end
			if (col_pos >= MAXW) col_pos = 0;
			if (row_pos >= MAXH) row_pos = 0;
			key = row_pos * MAXW + col_pos;
			exp_w = '0;
			if (!seeded) begin
				mean_mem[key] = {pix, 8'h00};
				wt_mem[key] = 16'hFFFF;
				dev_mem[key] = {dev_init, 8'h00};
				exp_w.background_value = pix;
			end else if (row_pos == act_row) begin
				a = alpha;
				mean = mean_mem[key];
				dev = dev_mem[key];
				wt = wt_mem[key];
				mint = mean >> 8;
				diff = (pix > mint) ? pix - mint : mint - pix;
				decayed = (wt * (65536 - a) + 32768) >> 16;
				exp_w.row_updated = 1'b1;
				if (diff * 256 <= band * dev) begin
					wn = decayed + a;
					if (wn > 65535) wn = 65535;
					exp_w.model_matched = 1'b1;
					p = (a >= wn) ? 65536 : (a << 16) / wn;
					q = 65536 - p;
					mnew = (q * mean + p * (longint'(pix) << 8) + 32768) >> 16;
					d = longint'(pix) * 256 - longint'(mnew);
					d2 = d * d;
					var_n = (q * (dev * dev) + p * d2 + 32768) >> 16;
					if (var_n > 64'hFFFF_FFFF) var_n = 64'hFFFF_FFFF;
					wt_mem[key] = wn[15:0];
					mean_mem[key] = mnew[15:0];
					dev_mem[key] = 16'(root_floor(var_n));
					mean = mnew;
				end else begin
					wt_mem[key] = decayed[15:0];
				end
				exp_w.background_value = 8'(mean >> 8);
			end else begin
				exp_w.background_value = 8'(mean_mem[key] >> 8);
			end
			// raster advance; frame end seeds or moves the active row
			if (col_pos + 1 >= w) begin
				col_pos = 0;
				if (row_pos + 1 >= h) begin
					row_pos = 0;
					if (!seeded) seeded = 1;
					else act_row = (act_row + 1 >= h) ? 0 : act_row + 1;
				end else begin
					row_pos++;
				end
			end else begin
				col_pos++;
			end
			pending_words.push_back(exp_w);
		endfunction

		function void check_word(bg_word_t got);
			bg_word_t exp_w;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp_w = pending_words.pop_front();
			if (got.background_value !== exp_w.background_value) begin
				$display("%0t: background_value expected %0d actual %0d", $time,
					exp_w.background_value, got.background_value);
				errors++;
			end
			if (got.row_updated !== exp_w.row_updated) begin
				$display("%0t: row_updated expected %0d actual %0d", $time,
					exp_w.row_updated, got.row_updated);
				errors++;
			end
			if (got.model_matched !== exp_w.model_matched) begin
				$display("%0t: model_matched expected %0d actual %0d", $time,
					exp_w.model_matched, got.model_matched);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gbm_pixel_if  pix_ch();
	gbm_result_if res_ch();

	gaussian_background_model u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_ch.sink),
		.results   (res_ch.source),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bg_scoreboard sb = new();
	longint cycles = 0;
	int words_sent = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("gaussian_background_model test failed");
			$finish;
		end
	end

	// Check every word that the block hands over.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_word({res_ch.background_value, res_ch.row_updated, res_ch.model_matched});
	end

	// Result side: random back-pressure, plus one long hold-off in the middle
	// of a frame so the queue fills and pixels.ready has to drop.
	initial begin
		int n;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		while (words_sent < 200) begin
			n = $urandom_range(0, 99);
			if (n < 65) begin
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else if (n < 95) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(15, 40)) @(posedge clk);
			end
		end
		res_ch.ready <= 1'b0;
		repeat (400) @(posedge clk);
		forever begin
			n = $urandom_range(0, 99);
			res_ch.ready <= (n < 75);
			repeat (n < 97 ? $urandom_range(1, 12) : $urandom_range(15, 40)) @(posedge clk);
		end
	end

	// Offer one pixel word; return at the edge it is taken.
	task automatic send_pixel(bit [7:0] pix, bit sof);
		int n;
		n = $urandom_range(0, 99);
		if (n >= 60) begin
			pix_ch.valid <= 1'b0;
			repeat (n < 92 ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_value <= pix;
		pix_ch.start_of_frame <= sof;
		do @(posedge clk); while (!pix_ch.ready);
		sb.note_pixel(pix, sof);
		words_sent++;
	endtask

	// Pick a pixel near the modeled mean most of the time so matches happen.
	function automatic bit [7:0] pick_pixel(bit sof);
		int m;
		if ($urandom_range(0, 99) < 25) return 8'($urandom_range(0, 255));
		m = sb.next_mean(sof) + $urandom_range(0, 16) - 8;
		if (m < 0) m = 0;
		if (m > 255) m = 255;
		return 8'(m);
	endfunction

	// Drop valid and wait until every expected word is back, then flush.
	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Write all five registers back to back; call only while idle.
	task automatic configure(int w, int h, int lr, int mf, int dv);
		set_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		set_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
		set_reg(REG_LEARNING_RATE, CFG_DATA_W'(lr));
		set_reg(REG_MATCH_FACTOR, CFG_DATA_W'(mf));
		set_reg(REG_INITIAL_DEVIATION, CFG_DATA_W'(dv));
		cfg_write <= 1'b0;
	endtask

	task automatic send_frame(int len, bit with_sof);
		bit sof;
		for (int i = 0; i < len; i++) begin
			sof = (i == 0) && with_sof;
			send_pixel(pick_pixel(sof), sof);
		end
	endtask

	initial begin
		int w, h, len;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel_value <= '0;
		pix_ch.start_of_frame <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Oversized width and height (clamped to max), partial frame that
		// never completes: seeding only, no initialization.
		configure(1023, 1023, 65535, 15, 0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'h55, 1'b0);
		for (int i = 0; i < 6; i++) send_pixel(8'($urandom_range(0, 255)), 1'b0);
		drain();

		// Seeding frame: 24x6 bounds every later position, so no unseeded
		// entry is ever read. Early start_of_frame abandons the partial one.
		configure(24, 6, 65535, 15, 255);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd0, 1'b0);
		send_frame(24 * 6, 1'b1);
		drain();

		// Alpha of one: ratio saturates, mean jumps to the pixel.
		configure(24, 6, 65535, 15, 36);
		send_frame(24 * 6, 1'b1);
		drain();
		// Alpha zero and match factor zero apply literally.
		configure(24, 6, 0, 0, 36);
		send_frame(24 * 6, 1'b1);
		drain();
		// Width and height of zero act as one; active row past height wraps.
		configure(0, 0, 1, 15, 36);
		send_frame(3, 1'b1);
		drain();
		configure(1, 1, 40000, 1, 0);
		send_frame(4, 1'b0);
		drain();

		// Random phases: mostly whole frames, some cut short or missing
		// their start marker.
		while (words_sent < 750) begin
			w = $urandom_range(0, 24);
			h = $urandom_range(0, 6);
			configure(w, h, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(200, 9000), $urandom_range(0, 15), $urandom_range(0, 255));
			repeat ($urandom_range(2, 6)) begin
				len = (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
				if ($urandom_range(0, 9) == 0 && len > 1) len = $urandom_range(1, len - 1);
				send_frame(len, $urandom_range(0, 19) != 0);
			end
			drain();
		end

		if (sb.errors == 0)
			$display("gaussian_background_model test passed");
		else
			$display("gaussian_background_model test failed");
		$finish;
	end
endmodule

// File: gaussian_background_model.f
+incdir+hdl
hdl/gbm_pkg.sv
hdl/gbm_if.sv
hdl/gbm_div.sv
hdl/gbm_sqrt.sv
hdl/gbm_front.sv
hdl/gbm_back.sv
hdl/gaussian_background_model.sv
tb/tb.sv
